// ===== rtl/poly_voice_allocator_core_defines.svh =====
// Assertion macros used by the voice allocator core.
`ifndef POLY_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define PVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pva_pkg.sv =====
package pva_pkg;

    // Default sizes of the voice bank and the age counter.
    localparam int unsigned PVA_VOICES   = 8;
    localparam int unsigned PVA_AGE_BITS = 16;

    // Event kinds.
    localparam logic KIND_NOTE_ON  = 1'b0;
    localparam logic KIND_NOTE_OFF = 1'b1;

    // Envelope codes that matter for allocation.
    localparam logic [1:0] ENV_IDLE    = 2'd0;
    localparam logic [1:0] ENV_RELEASE = 2'd1;

    // One input event.
    typedef struct packed {
        logic        kind;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] voice_env;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic       start_valid;
        logic [2:0] start_voice;
        logic [6:0] start_note;
        logic [6:0] start_velocity;
        logic [7:0] stop_mask;
    } t_out_item;

endpackage

// ===== rtl/poly_voice_allocator_core.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------
// event    | in        | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// result   | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// An event is accepted, then a serial scan visits the voices (a note on stops at
// the first idle or releasing voice), and a commit step updates the voice tables
// and loads the output register.
// The scan shares one note comparator and one age comparator across all voices.
// Reset (synchronous, active low) clears the stored notes, ages and the counter.
// A stalled result holds in the output register; the next event is still accepted
// and waits only at its commit step until the register frees.
module poly_voice_allocator_core #(
    parameter int unsigned VOICES   = pva_pkg::PVA_VOICES,
    parameter int unsigned AGE_BITS = pva_pkg::PVA_AGE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pva_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pva_pkg::t_out_item o_out_data
);
    import pva_pkg::*;

    `include "poly_voice_allocator_core_defines.svh"

    localparam int unsigned VIDX = $clog2(VOICES);
    localparam logic [VIDX-1:0] LAST_IDX = VIDX'(VOICES - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    t_in_item            r_in;
    logic [VIDX-1:0]     r_idx;
    logic [VIDX-1:0]     r_pick;
    logic [AGE_BITS-1:0] r_best;
    logic                r_all_idle;
    logic [7:0]          r_mask;
    logic [AGE_BITS-1:0] r_age_cnt;
    logic [6:0]          r_voice_note [VOICES];
    logic [AGE_BITS-1:0] r_voice_age  [VOICES];
    logic                r_out_valid;
    t_out_item           r_out;

    logic       w_accept;
    logic       w_out_free;
    logic [2:0] w_idx3;
    logic       w_in_field;
    logic [1:0] w_env;
    logic       w_free_voice;

    // Handshake terms.
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Envelope code of the voice under the scan; voices past the field read as idle.
    assign w_idx3     = 3'(r_idx);
    assign w_in_field = (32'(r_idx) < 32'd8);
    always_comb begin
        w_env = ENV_IDLE;
        if (w_in_field) begin
            w_env = r_in.voice_env[{w_idx3, 1'b0} +: 2];
        end
    end
    assign w_free_voice = (w_env == ENV_IDLE) || (w_env == ENV_RELEASE);

    // Sequencer, voice tables and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_age_cnt   <= '0;
            r_idx       <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_voice_note[v] <= '0;
                r_voice_age[v]  <= '0;
            end
        end else begin
            // The output register loads at commit and empties once its item is taken.
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in       <= i_in_data;
                        r_idx      <= '0;
                        r_pick     <= '0;
                        r_best     <= '0;
                        r_all_idle <= 1'b1;
                        r_mask     <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_in.kind == KIND_NOTE_ON) begin
                        if (w_free_voice) begin
                            r_pick  <= r_idx;
                            r_state <= S_DONE;
                        end else begin
                            // Keep the oldest voice; an equal age keeps the lower index.
                            if (r_idx == '0 || r_voice_age[r_idx] < r_best) begin
                                r_best <= r_voice_age[r_idx];
                                r_pick <= r_idx;
                            end
                            if (r_idx == LAST_IDX) begin
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end else begin
                        if (w_env != ENV_IDLE) begin
                            r_all_idle <= 1'b0;
                        end
                        if (w_in_field && r_voice_note[r_idx] == r_in.note) begin
                            r_mask[w_idx3] <= 1'b1;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        if (r_in.kind == KIND_NOTE_ON) begin
                            r_voice_note[r_pick]  <= r_in.note;
                            r_voice_age[r_pick]   <= r_age_cnt;
                            if (r_age_cnt != AGE_MAX) begin
                                r_age_cnt <= r_age_cnt + 1'b1;
                            end
                            r_out.start_valid    <= 1'b1;
                            r_out.start_voice    <= 3'(r_pick);
                            r_out.start_note     <= r_in.note;
                            r_out.start_velocity <= r_in.velocity;
                            r_out.stop_mask      <= '0;
                        end else begin
                            if (r_all_idle) begin
                                r_age_cnt <= '0;
                            end
                            r_out.start_valid    <= 1'b0;
                            r_out.start_voice    <= '0;
                            r_out.start_note     <= '0;
                            r_out.start_velocity <= '0;
                            r_out.stop_mask      <= r_mask;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A note on result never carries a stop mask.
    `PVA_ASSERT(a_on_no_mask, i_clk, i_rst_n, (o_out_valid && o_out_data.start_valid) |-> (o_out_data.stop_mask == '0), "note on result with a stop mask")

    // An accepted event makes the block busy in the next cycle.
    `PVA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "event accepted while a scan should be running")

    // The age counter only steps by one or clears.
    `PVA_ASSERT(a_age_step, i_clk, i_rst_n, (r_age_cnt != $past(r_age_cnt)) |-> ((r_age_cnt == $past(r_age_cnt) + 1'b1) || (r_age_cnt == '0)), "age counter jumped")

    // The output register is empty in the cycle after a reset edge.
    `PVA_ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // The scan index never passes the last voice.
    `PVA_ASSERT(a_idx_range, i_clk, i_rst_n, (r_idx <= LAST_IDX), "scan index out of range")

endmodule

// ===== dv/poly_voice_allocator_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the voice allocator, predicts the result of every
// accepted event and compares it with what comes out of the block.
module poly_voice_allocator_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  pva_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  pva_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pva_pkg::*;

    localparam int NV = PVA_VOICES;

    // Mirror of the voice tables and the allocation counter.
    logic [6:0]              stored_note [NV];
    logic [PVA_AGE_BITS-1:0] stored_age  [NV];
    logic [PVA_AGE_BITS-1:0] alloc_count;

    t_out_item voice_results_due[$];
    int        mismatches = 0;

    // Applies one event to the mirrored state and returns the result it causes.
    function automatic t_out_item allocate_voice(input t_in_item ev);
        t_out_item               res;
        int                      pick;
        logic                    found;
        logic                    have_best;
        logic                    all_idle;
        logic [PVA_AGE_BITS-1:0] best;
        logic [1:0]              code;
        res = '0;
        if (ev.kind == KIND_NOTE_ON) begin
            pick      = 0;
            found     = 1'b0;
            have_best = 1'b0;
            best      = '0;
            // First free voice wins; otherwise the oldest busy one is stolen.
            for (int v = 0; v < NV; v++) begin
                if (!found) begin
                    code = (2 * v < 16) ? ev.voice_env[2*v +: 2] : ENV_IDLE;
                    if (code == ENV_IDLE || code == ENV_RELEASE) begin
                        pick  = v;
                        found = 1'b1;
                    end else if (!have_best || stored_age[v] < best) begin
                        best      = stored_age[v];
                        pick      = v;
                        have_best = 1'b1;
                    end
                end
            end
            stored_note[pick] = ev.note;
            stored_age[pick]  = alloc_count;
            if (alloc_count != '1) begin
                alloc_count = alloc_count + 1'b1;
            end
            res.start_valid    = 1'b1;
            res.start_voice    = pick[2:0];
            res.start_note     = ev.note;
            res.start_velocity = ev.velocity;
        end else begin
            all_idle = 1'b1;
            for (int v = 0; v < NV; v++) begin
                code = (2 * v < 16) ? ev.voice_env[2*v +: 2] : ENV_IDLE;
                if (code != ENV_IDLE) begin
                    all_idle = 1'b0;
                end
                if (v < 8 && stored_note[v] == ev.note) begin
                    res.stop_mask[v] = 1'b1;
                end
            end
            // A silent bank restarts the age sequence.
            if (all_idle) begin
                alloc_count = '0;
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Sample both channels at the rising edge; results before new events.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int v = 0; v < NV; v++) begin
                stored_note[v] = '0;
                stored_age[v]  = '0;
            end
            alloc_count = '0;
            voice_results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (voice_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result %h arrived with none expected",
                             $time, i_out_data);
                end else begin
                    want = voice_results_due.pop_front();
                    compare_field("start_valid", 8'(want.start_valid),
                                  8'(i_out_data.start_valid));
                    compare_field("start_voice", 8'(want.start_voice),
                                  8'(i_out_data.start_voice));
                    compare_field("start_note", 8'(want.start_note),
                                  8'(i_out_data.start_note));
                    compare_field("start_velocity", 8'(want.start_velocity),
                                  8'(i_out_data.start_velocity));
                    compare_field("stop_mask", want.stop_mask,
                                  i_out_data.stop_mask);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                voice_results_due.push_back(allocate_voice(i_in_data));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= voice_results_due.size();
    end

endmodule

// ===== dv/poly_voice_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module poly_voice_allocator_core_tb;
    import pva_pkg::*;

    // Envelope codes for busy voices; code three also counts as sounding.
    localparam logic [1:0] ENV_SOUNDING = 2'd2;
    localparam logic [1:0] ENV_CODE3    = 2'd3;

    localparam int RANDOM_EVENTS = 350;
    localparam int STEADY_ONS    = 20;
    localparam int SETTLE_CYCLES = PVA_VOICES + 8;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic steady      = 1'b0;

    logic [6:0] played_notes[$];

    poly_voice_allocator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    poly_voice_allocator_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic idle_now();
        return !steady && ($urandom_range(0, 99) < 27);
    endfunction

    // The result side stalls at random, except in the steady stretch.
    always @(negedge i_clk) begin
        out_stall <= idle_now();
    end

    // Envelope snapshot: a fully busy bank in four draws of ten, so that stealing happens often.
    function automatic logic [15:0] random_env();
        logic [15:0] env;
        int          style;
        int          free_voice;
        style      = $urandom_range(0, 9);
        free_voice = $urandom_range(0, PVA_VOICES - 1);
        env        = 16'($urandom_range(0, 16'hFFFF));
        if (style < 4) begin
            for (int v = 0; v < PVA_VOICES; v++) begin
                env[2*v+1] = 1'b1;
            end
        end else if (style < 6) begin
            for (int v = 0; v < PVA_VOICES; v++) begin
                env[2*v+1] = 1'b1;
            end
            env[2*free_voice +: 2] = (style == 4) ? ENV_IDLE : ENV_RELEASE;
        end else if (style == 6) begin
            env = {PVA_VOICES{ENV_IDLE}};
        end
        return env;
    endfunction

    // Offers one item and returns at the falling edge after it is taken.
    task automatic send_event(input logic kind, input logic [6:0] note,
                              input logic [6:0] vel, input logic [15:0] env);
        t_in_item ev;
        ev.kind      = kind;
        ev.note      = note;
        ev.velocity  = vel;
        ev.voice_env = env;
        while (idle_now()) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (kind == KIND_NOTE_ON) begin
            played_notes.push_back(note);
            if (played_notes.size() > 16) begin
                void'(played_notes.pop_front());
            end
        end
    endtask

    initial begin
        logic        kind;
        logic [6:0]  note;
        logic [15:0] env;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed events: reset contents, free-voice search, stealing, clears.
        send_event(KIND_NOTE_OFF, 7'd0, 7'd0, {8{ENV_IDLE}});
        send_event(KIND_NOTE_ON, 7'd127, 7'd127, {8{ENV_IDLE}});
        send_event(KIND_NOTE_ON, 7'd0, 7'd0, {ENV_RELEASE, {7{ENV_SOUNDING}}});
        send_event(KIND_NOTE_ON, 7'd64, 7'd1, {8{ENV_SOUNDING}});
        send_event(KIND_NOTE_ON, 7'd64, 7'd64, {8{ENV_CODE3}});
        send_event(KIND_NOTE_ON, 7'd1, 7'd100,
                   {{5{ENV_SOUNDING}}, ENV_RELEASE, {2{ENV_SOUNDING}}});
        send_event(KIND_NOTE_ON, 7'd2, 7'd2, {{7{ENV_SOUNDING}}, ENV_IDLE});
        send_event(KIND_NOTE_ON, 7'd3, 7'd3,
                   {ENV_SOUNDING, {3{ENV_CODE3}}, {2{ENV_SOUNDING}}, ENV_CODE3,
                    ENV_SOUNDING});
        send_event(KIND_NOTE_OFF, 7'd64, 7'd0, {8{ENV_SOUNDING}});
        send_event(KIND_NOTE_OFF, 7'd127, 7'd127, {8{ENV_RELEASE}});
        send_event(KIND_NOTE_OFF, 7'd0, 7'd0, {{7{ENV_IDLE}}, ENV_CODE3});
        send_event(KIND_NOTE_ON, 7'd5, 7'd5, {8{ENV_CODE3}});
        send_event(KIND_NOTE_OFF, 7'd0, 7'd0, {8{ENV_IDLE}});
        send_event(KIND_NOTE_ON, 7'd6, 7'd6, {8{ENV_CODE3}});
        send_event(KIND_NOTE_ON, 7'd7, 7'd7, {ENV_RELEASE, {7{ENV_CODE3}}});
        send_event(KIND_NOTE_OFF, 7'd6, 7'd0, {8{ENV_CODE3}});
        send_event(KIND_NOTE_OFF, 7'd100, 7'd5, {8{ENV_IDLE}});

        // Steady stretch: quick note ons that find voice 0 free, then steals
        // from a fully sounding bank, all without any idling.
        steady = 1'b1;
        for (int n = 0; n < STEADY_ONS; n++) begin
            env      = 16'($urandom_range(0, 16'hFFFF));
            env[1:0] = ($urandom_range(0, 1) != 0) ? ENV_RELEASE : ENV_IDLE;
            send_event(KIND_NOTE_ON, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)), env);
        end
        for (int n = 0; n < 12; n++) begin
            send_event(KIND_NOTE_ON, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)),
                       (n % 2 == 0) ? {8{ENV_SOUNDING}} : {8{ENV_CODE3}});
        end
        send_event(KIND_NOTE_OFF, 7'($urandom_range(0, 127)), 7'd0, {8{ENV_IDLE}});
        steady = 1'b0;

        // Random traffic: note offs mostly target notes that were played recently.
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            kind = ($urandom_range(0, 99) < 60) ? KIND_NOTE_ON : KIND_NOTE_OFF;
            if (kind == KIND_NOTE_OFF && played_notes.size() > 0 &&
                $urandom_range(0, 99) < 70) begin
                note = played_notes[$urandom_range(0, played_notes.size() - 1)];
            end else if ($urandom_range(0, 99) < 30) begin
                note = 7'($urandom_range(60, 63));
            end else begin
                note = 7'($urandom_range(0, 127));
            end
            send_event(kind, note, 7'($urandom_range(0, 127)), random_env());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
